FILE: hw/rtl/cplg_pkg.sv
// Shared types and constants of the performance-level governor.
package cplg_pkg;

  localparam int unsigned CPU_W      = 6;
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned SLICE_W    = 32;
  localparam int unsigned LVL_W      = 11;
  localparam int unsigned PERF_SHIFT = 10;
  localparam int unsigned QUO_W      = PERF_SHIFT + 1;
  localparam int unsigned REM_W      = SLICE_W + PERF_SHIFT;
  localparam int unsigned DSH_W      = STAMP_W + PERF_SHIFT;
  localparam int unsigned DIV_CNT_W  = $clog2(QUO_W);
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = LVL_W;

  localparam logic [LVL_W-1:0] PERF_FULL = LVL_W'(1024);
  localparam logic [LVL_W-1:0] PERF_HALF = LVL_W'(512);

  localparam logic             FREQ_ENABLE_RST = 1'b1;
  localparam logic [LVL_W-1:0] LOW_THR_RST     = LVL_W'(256);
  localparam logic [LVL_W-1:0] HIGH_THR_RST    = LVL_W'(768);

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_APPLY  = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FREQ_ENABLE = 2'd0,
    CFG_LOW_THR     = 2'd1,
    CFG_HIGH_THR    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_WRITE,
    ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic clr_en;
    logic div_start;
    logic div_step;
    logic wr_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ev_ok;
    logic is_apply;
    logic elapsed_zero;
    logic div_last;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: hw/rtl/cplg_ctrl.sv
// Sequencing state machine of the performance-level governor.
module cplg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cplg_pkg::dp_stat_t stat_i,
  output cplg_pkg::dp_cmd_t  cmd_o
);
  import cplg_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (!stat_i.ev_ok) begin
          state_d = ST_IDLE;
        end else if (stat_i.is_apply) begin
          state_d = ST_EMIT;
        end else if (stat_i.elapsed_zero) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat_i.div_last) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      ST_EMIT: begin
        if (!stat_i.out_busy) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.div_start = stat_i.ev_ok && !stat_i.is_apply && !stat_i.elapsed_zero;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_WRITE: begin
        cmd_o.wr_en = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.out_load = !stat_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // A division always runs its full count before the write-back.
  a_write_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> $past(state_q == ST_DIV) && $past(stat_i.div_last))
    else $error("write-back without a finished division");
  // Once an item is taken the block is busy until it is finished.
  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o)
    else $error("ready high right after an item was taken");
`endif
endmodule

FILE: hw/rtl/cplg_dp.sv
// Datapath: per-CPU tables, elapsed time, shift-subtract divider and target register.
module cplg_dp #(
  parameter int unsigned NUM_CPUS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cplg_pkg::dp_cmd_t             cmd_i,
  output cplg_pkg::dp_stat_t            stat_o,
  input  logic                          freq_enable_i,
  input  logic [cplg_pkg::LVL_W-1:0]    low_threshold_i,
  input  logic [cplg_pkg::LVL_W-1:0]    high_threshold_i,
  input  logic                          command_i,
  input  logic [cplg_pkg::CPU_W-1:0]    cpu_index_i,
  input  logic [cplg_pkg::STAMP_W-1:0]  now_ns_i,
  input  logic [cplg_pkg::SLICE_W-1:0]  used_slice_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cplg_pkg::CPU_W-1:0]    target_cpu_o,
  output logic [cplg_pkg::LVL_W-1:0]    perf_target_o
);
  import cplg_pkg::*;

  localparam int unsigned IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int unsigned EXT_W = ((IDX_W > CPU_W) ? IDX_W : CPU_W) + 1;

  logic [STAMP_W-1:0] stamp_mem [NUM_CPUS];
  logic [LVL_W-1:0]   lvl_mem   [NUM_CPUS];

  logic               is_apply_q;
  logic               ev_ok_q;
  logic [CPU_W-1:0]   cpu_q;
  logic [IDX_W-1:0]   addr_q;
  logic [STAMP_W-1:0] now_q;
  logic [SLICE_W-1:0] slice_q;
  logic [STAMP_W-1:0] stamp_rd_q;
  logic [LVL_W-1:0]   lvl_rd_q;
  logic [REM_W-1:0]   rem_q;
  logic [DSH_W-1:0]   dsh_q;
  logic [QUO_W-1:0]   quo_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [IDX_W-1:0]   clr_cnt_q;
  logic               out_valid_q;
  logic [CPU_W-1:0]   out_cpu_q;
  logic [LVL_W-1:0]   out_target_q;

  logic [EXT_W-1:0]   cpu_ext;
  logic [IDX_W-1:0]   rd_addr;
  logic               in_range;
  logic [STAMP_W-1:0] elapsed;
  logic               div_ge;
  logic [LVL_W-1:0]   util;
  logic [LVL_W:0]     lvl_sum;
  logic [LVL_W-1:0]   lvl_new;
  logic [LVL_W-1:0]   target;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [STAMP_W-1:0] stamp_wdata;
  logic [LVL_W-1:0]   lvl_wdata;

  assign cpu_ext  = EXT_W'(cpu_index_i);
  assign rd_addr  = cpu_ext[IDX_W-1:0];
  assign in_range = cpu_ext < EXT_W'(NUM_CPUS);

  assign elapsed = now_q - stamp_rd_q;
  assign div_ge  = {{(DSH_W-REM_W){1'b0}}, rem_q} >= dsh_q;

  // A quotient of 1024 or more saturates to full scale.
  assign util    = quo_q[QUO_W-1] ? PERF_FULL : {1'b0, quo_q[QUO_W-2:0]};
  assign lvl_sum = {1'b0, lvl_rd_q} - {3'b000, lvl_rd_q[LVL_W-1:2]}
                 + {3'b000, util[LVL_W-1:2]};
  assign lvl_new = lvl_sum[LVL_W-1:0];

  always_comb begin
    if (lvl_rd_q >= high_threshold_i) begin
      target = PERF_FULL;
    end else if (lvl_rd_q <= low_threshold_i) begin
      target = PERF_HALF;
    end else begin
      target = lvl_rd_q;
    end
  end

  assign mem_we      = cmd_i.clr_en || cmd_i.wr_en;
  assign wr_addr     = cmd_i.clr_en ? clr_cnt_q : addr_q;
  assign stamp_wdata = cmd_i.clr_en ? '0 : now_q;
  assign lvl_wdata   = cmd_i.clr_en ? '0 : lvl_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stamp_mem[wr_addr] <= stamp_wdata;
      lvl_mem[wr_addr]   <= lvl_wdata;
    end
    if (cmd_i.load) begin
      stamp_rd_q <= stamp_mem[rd_addr];
      lvl_rd_q   <= lvl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cpu_q   <= cpu_index_i;
      addr_q  <= rd_addr;
      now_q   <= now_ns_i;
      slice_q <= used_slice_i;
    end
    if (cmd_i.div_start) begin
      rem_q <= {slice_q, {PERF_SHIFT{1'b0}}};
      dsh_q <= {elapsed, {PERF_SHIFT{1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (div_ge) rem_q <= rem_q - dsh_q[REM_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], div_ge};
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.out_load) begin
      out_cpu_q    <= cpu_q;
      out_target_q <= target;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_apply_q  <= 1'b0;
      ev_ok_q     <= 1'b0;
      div_cnt_q   <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        is_apply_q <= (command_i == CMD_APPLY);
        ev_ok_q    <= freq_enable_i && in_range;
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o              = '0;
    stat_o.clr_last     = clr_cnt_q == IDX_W'(NUM_CPUS - 1);
    stat_o.ev_ok        = ev_ok_q;
    stat_o.is_apply     = is_apply_q;
    stat_o.elapsed_zero = elapsed == '0;
    stat_o.div_last     = div_cnt_q == DIV_CNT_W'(QUO_W - 1);
    stat_o.out_busy     = out_valid_q && !out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign target_cpu_o  = out_cpu_q;
  assign perf_target_o = out_target_q;

`ifndef NO_ASSERTIONS
  a_target_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_target_q <= PERF_FULL)
    else $error("performance target above full scale");
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && lvl_rd_q <= PERF_FULL) |-> lvl_new <= PERF_FULL)
    else $error("smoothed level left its range");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q || out_ready_i)
    else $error("pending result overwritten");
`endif
endmodule

FILE: hw/rtl/cpu_perf_level_governor_core.sv
// Per-CPU performance-level governor: smoothed utilization with threshold-based targets.
//
// Input channel (in_valid_i/in_ready_o) carries one event per item: a record
// (command 0) updates the CPU's smoothed level from used_slice_i and the time
// since its previous record; an apply (command 1) produces one result item on
// the output channel (out_valid_o/out_ready_i) with the CPU and its target.
// The configuration port writes freq_enable, low_threshold and high_threshold
// by index at any edge with cfg_we_i high; write it only while the block is idle.
// One item is handled at a time. A record passes through evaluation, the
// bit-serial divider's 11 shift-subtract steps and write-back before the block
// is ready again; a disabled block or an out-of-range CPU, and for a record a
// zero elapsed time, end the item after evaluation with no update or result.
// An apply's result shows in the same cycle as the block is ready again.
// The result sits in an output register: a stalled receiver holds it there,
// and the next item is still taken; a second apply waits until the register
// frees. After reset the per-CPU tables are cleared one entry per cycle, with
// in_ready_o low until all are clear; configuration returns to its defaults.
module cpu_perf_level_governor_core #(
  parameter int unsigned NUM_CPUS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cplg_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [cplg_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [cplg_pkg::CPU_W-1:0]        cpu_index_i,
  input  logic [cplg_pkg::STAMP_W-1:0]      now_ns_i,
  input  logic [cplg_pkg::SLICE_W-1:0]      used_slice_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cplg_pkg::CPU_W-1:0]        target_cpu_o,
  output logic [cplg_pkg::LVL_W-1:0]        perf_target_o
);
  import cplg_pkg::*;

  logic             freq_enable_q;
  logic [LVL_W-1:0] low_thr_q;
  logic [LVL_W-1:0] high_thr_q;
  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_enable_q <= FREQ_ENABLE_RST;
      low_thr_q     <= LOW_THR_RST;
      high_thr_q    <= HIGH_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FREQ_ENABLE: freq_enable_q <= cfg_wdata_i[0];
        CFG_LOW_THR:     low_thr_q     <= cfg_wdata_i[LVL_W-1:0];
        CFG_HIGH_THR:    high_thr_q    <= cfg_wdata_i[LVL_W-1:0];
        default: begin
          freq_enable_q <= freq_enable_q;
        end
      endcase
    end
  end

  cplg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  cplg_dp #(
    .NUM_CPUS (NUM_CPUS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .freq_enable_i    (freq_enable_q),
    .low_threshold_i  (low_thr_q),
    .high_threshold_i (high_thr_q),
    .command_i        (command_i),
    .cpu_index_i      (cpu_index_i),
    .now_ns_i         (now_ns_i),
    .used_slice_i     (used_slice_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .target_cpu_o     (target_cpu_o),
    .perf_target_o    (perf_target_o)
  );

`ifndef NO_ASSERTIONS
  a_cfg_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_addr_i == CFG_FREQ_ENABLE) |=> freq_enable_q == $past(cfg_wdata_i[0]))
    else $error("enable write lost");
`endif
endmodule

FILE: sim/cpu_perf_level_governor_core_test.sv
// Self-checking testbench for the performance-level governor core: directed table, then random phases.
module cpu_perf_level_governor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cplg_pkg::*;

  localparam int unsigned NUM_CPUS       = 64;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 200;
  localparam int unsigned OFF_ITEMS      = 60;
  localparam int unsigned NUM_PHASES     = 8;

  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    logic [LVL_W-1:0] level;
  } target_t;

  typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic               cmd;
    logic [CPU_W-1:0]   cpu;
    logic [STAMP_W-1:0] now;
    logic [SLICE_W-1:0] slice;
    bit                 typed;
    logic [LVL_W-1:0]   typed_level;
    cfg_idx_e           reg_idx;
    logic [LVL_W-1:0]   reg_data;
  } stim_row_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic                  command_i    = 1'b0;
  logic [CPU_W-1:0]      cpu_index_i  = '0;
  logic [STAMP_W-1:0]    now_ns_i     = '0;
  logic [SLICE_W-1:0]    used_slice_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [CPU_W-1:0]      target_cpu_o;
  logic [LVL_W-1:0]      perf_target_o;

  // Predictor state and configuration copy.
  logic [STAMP_W-1:0] pred_stamp [NUM_CPUS];
  logic [LVL_W-1:0]   pred_level [NUM_CPUS];
  logic               pred_enable = FREQ_ENABLE_RST;
  logic [LVL_W-1:0]   pred_low    = LOW_THR_RST;
  logic [LVL_W-1:0]   pred_high   = HIGH_THR_RST;

  target_t   expected_targets[$];
  stim_row_t stim_rows[$];
  bit        idle_on = 1'b1;
  int        fail_count = 0;
  int        quiet_cycles = 0;

  cpu_perf_level_governor_core #(
    .NUM_CPUS(NUM_CPUS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .cpu_index_i  (cpu_index_i),
    .now_ns_i     (now_ns_i),
    .used_slice_i (used_slice_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .target_cpu_o (target_cpu_o),
    .perf_target_o(perf_target_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Applies one event to the predicted state; returns 1 with the target when a result follows.
  function automatic bit governor_model(input logic cmd, input logic [CPU_W-1:0] cpu,
                                        input logic [STAMP_W-1:0] now,
                                        input logic [SLICE_W-1:0] slice,
                                        output logic [LVL_W-1:0] level_out);
    logic [63:0]      elapsed;
    logic [63:0]      util;
    logic [LVL_W-1:0] lvl;
    level_out = '0;
    if (!pred_enable || 32'(cpu) >= NUM_CPUS) return 1'b0;
    lvl = pred_level[cpu];
    if (cmd == CMD_RECORD) begin
      elapsed = now - pred_stamp[cpu];
      if (elapsed == 64'd0) return 1'b0;
      util = ({32'd0, slice} << PERF_SHIFT) / elapsed;
      if (util > 64'(PERF_FULL)) util = 64'(PERF_FULL);
      pred_level[cpu] = LVL_W'((64'(lvl) - 64'(lvl >> 2)) + (util >> 2));
      pred_stamp[cpu] = now;
      return 1'b0;
    end
    if (lvl >= pred_high) begin
      level_out = PERF_FULL;
    end else if (lvl <= pred_low) begin
      level_out = PERF_HALF;
    end else begin
      level_out = lvl;
    end
    return 1'b1;
  endfunction

  task automatic report_bad(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Presents one item and holds it until the block takes it.
  task automatic send_event(input logic cmd, input logic [CPU_W-1:0] cpu,
                            input logic [STAMP_W-1:0] now, input logic [SLICE_W-1:0] slice,
                            input bit typed, input logic [LVL_W-1:0] typed_level);
    logic [LVL_W-1:0] lvl;
    bit               has_result;
    while (idle_on && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    cpu_index_i  <= cpu;
    now_ns_i     <= now;
    used_slice_i <= slice;
    do @(posedge clk_i); while (!in_ready_o);
    has_result = governor_model(cmd, cpu, now, slice, lvl);
    if (has_result) begin
      expected_targets.push_back('{cpu: cpu, level: (typed ? typed_level : lvl)});
    end
  endtask

  // Stops the sender, lets all results drain and gives a pending record time to finish.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_targets.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [LVL_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FREQ_ENABLE: pred_enable = data[0];
      CFG_LOW_THR:     pred_low    = data;
      CFG_HIGH_THR:    pred_high   = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic void add_event(input logic cmd, input logic [CPU_W-1:0] cpu,
                                    input logic [STAMP_W-1:0] now,
                                    input logic [SLICE_W-1:0] slice,
                                    input bit typed, input logic [LVL_W-1:0] typed_level);
    stim_row_t row;
    row = '{kind: ROW_EVENT, cmd: cmd, cpu: cpu, now: now, slice: slice, typed: typed,
            typed_level: typed_level, reg_idx: CFG_FREQ_ENABLE, reg_data: '0};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_write(input cfg_idx_e idx, input logic [LVL_W-1:0] data);
    stim_row_t row;
    row = '{kind: ROW_WRITE, cmd: CMD_RECORD, cpu: '0, now: '0, slice: '0, typed: 1'b0,
            typed_level: '0, reg_idx: idx, reg_data: data};
    stim_rows.push_back(row);
  endfunction

  // Receiver stalls at random, about 30 percent of the time, while idling is on.
  always @(posedge clk_i) begin
    out_ready_i <= idle_on ? ($urandom_range(99) >= 30) : 1'b1;
  end

  always @(posedge clk_i) begin
    target_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_targets.size() == 0) begin
        report_bad($sformatf("unexpected result: cpu %0d target %0d",
                             target_cpu_o, perf_target_o));
      end else begin
        want = expected_targets.pop_front();
        if (target_cpu_o !== want.cpu || perf_target_o !== want.level) begin
          report_bad($sformatf("mismatch: cpu exp %0d got %0d, target exp %0d got %0d",
                               want.cpu, target_cpu_o, want.level, perf_target_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [CPU_W-1:0]   cpu;
    logic [STAMP_W-1:0] now;
    logic [SLICE_W-1:0] slice;
    logic [31:0]        delta;
    logic [LVL_W-1:0]   lo;
    logic [LVL_W-1:0]   hi;
    logic               en;
    int                 n_items;
    int                 load_max;
    int                 pick;

    for (int i = 0; i < NUM_CPUS; i++) begin
      pred_stamp[i] = '0;
      pred_level[i] = '0;
    end

    // Directed part. Levels start at zero, so the first applies land on half scale.
    add_event(CMD_APPLY,  6'd0,  64'd0, 32'd0, 1'b1, PERF_HALF);
    add_event(CMD_RECORD, 6'd0,  64'd0, 32'hFFFF_FFFF, 1'b0, '0);  // zero elapsed time
    add_event(CMD_APPLY,  6'd0,  64'd0, 32'd0, 1'b1, PERF_HALF);
    add_event(CMD_RECORD, 6'd63, 64'd1, 32'hFFFF_FFFF, 1'b0, '0);  // utilization saturates
    add_event(CMD_APPLY,  6'd63, '1, '1, 1'b0, '0);
    add_event(CMD_RECORD, 6'd63, 64'd2, 32'hFFFF_FFFF, 1'b0, '0);
    add_event(CMD_APPLY,  6'd63, 64'd0, 32'd0, 1'b0, '0);
    add_event(CMD_RECORD, 6'd5,  '1, 32'd0, 1'b0, '0);
    add_event(CMD_RECORD, 6'd5,  64'd0, 32'd1, 1'b0, '0);          // timestamp wraps around
    add_event(CMD_APPLY,  6'd5,  64'd0, 32'd0, 1'b0, '0);
    add_event(CMD_RECORD, 6'd42, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0, '0);
    add_event(CMD_RECORD, 6'd42, 64'h8000_0000_0000_03E8, 32'd500, 1'b0, '0);
    add_write(CFG_FREQ_ENABLE, 11'h7FE);                              // disabled
    add_event(CMD_APPLY,  6'd63, 64'd0, 32'd0, 1'b0, '0);
    add_event(CMD_RECORD, 6'd63, 64'd100, 32'd100, 1'b0, '0);
    add_write(CFG_FREQ_ENABLE, 11'h001);
    add_event(CMD_APPLY,  6'd63, 64'd0, 32'd0, 1'b0, '0);
    add_write(CFG_LOW_THR, 11'h7FF);                                  // crossed thresholds
    add_write(CFG_HIGH_THR, 11'd0);
    add_event(CMD_APPLY,  6'd0,  64'd0, 32'd0, 1'b1, PERF_FULL);
    add_write(CFG_HIGH_THR, 11'h7FF);
    add_write(CFG_LOW_THR, 11'd0);
    add_event(CMD_APPLY,  6'd0,  64'd0, 32'd0, 1'b1, PERF_HALF);
    add_event(CMD_APPLY,  6'd63, 64'd0, 32'd0, 1'b0, '0);
    add_event(CMD_APPLY,  6'd42, 64'd0, 32'd0, 1'b0, '0);
    add_write(CFG_LOW_THR, 11'd1024);
    add_write(CFG_HIGH_THR, 11'd1024);
    add_event(CMD_APPLY,  6'd63, 64'd0, 32'd0, 1'b0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        settle_block();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_data);
      end else begin
        send_event(stim_rows[i].cmd, stim_rows[i].cpu, stim_rows[i].now, stim_rows[i].slice,
                   stim_rows[i].typed, stim_rows[i].typed_level);
      end
    end

    // Random phases, each under its own threshold setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_block();
      en = 1'b1;
      case (ph)
        0: begin lo = LOW_THR_RST; hi = HIGH_THR_RST; end
        1: begin lo = 11'd0; hi = 11'd1024; end
        2: begin lo = 11'd1024; hi = 11'h7FF; end
        4: begin
          en = 1'b0;
          lo = LVL_W'($urandom_range(1024));
          hi = LVL_W'($urandom_range(1024));
        end
        5: begin lo = 11'h7FF; hi = 11'd0; end
        6: begin lo = LVL_W'($urandom_range(2047)); hi = LVL_W'($urandom_range(2047)); end
        7: begin
          lo = LVL_W'($urandom_range(300, 500));
          hi = LVL_W'(32'(lo) + $urandom_range(200));
        end
        default: begin lo = LVL_W'($urandom_range(1024)); hi = LVL_W'($urandom_range(1024)); end
      endcase
      write_reg(CFG_FREQ_ENABLE, {10'($urandom), en});
      write_reg(CFG_LOW_THR, lo);
      write_reg(CFG_HIGH_THR, hi);
      idle_on  = (ph != 3);
      n_items  = en ? PHASE_ITEMS : OFF_ITEMS;
      load_max = $urandom_range(20, 260);

      for (int k = 0; k < n_items; k++) begin
        // Half the traffic goes to a few CPUs so their levels build up.
        cpu = ($urandom_range(1) == 1) ? CPU_W'($urandom_range(3)) : CPU_W'($urandom_range(63));
        if ($urandom_range(99) < 35) begin
          send_event(CMD_APPLY, cpu, {$urandom, $urandom}, $urandom, 1'b0, '0);
        end else begin
          pick  = $urandom_range(99);
          slice = $urandom;
          if (pick < 65) begin
            delta = $urandom_range(1, 5000);
            now   = pred_stamp[cpu] + 64'(delta);
            slice = (delta * $urandom_range(load_max)) / 100;
          end else if (pick < 73) begin
            now = pred_stamp[cpu];
          end else if (pick < 80) begin
            now = pred_stamp[cpu] - 64'($urandom_range(1, 1000));
          end else if (pick < 88) begin
            now = pred_stamp[cpu] + 64'($urandom_range(1, 64));
          end else begin
            now = {$urandom, $urandom};
          end
          send_event(CMD_RECORD, cpu, now, slice, 1'b0, '0);
        end
        if ($urandom_range(99) == 0) settle_block();
      end
    end

    settle_block();
    if (fail_count == 0 && expected_targets.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
